/* sv/tcce_pkg.sv */
// Shared types, widths and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  // Sizes of the history stack and the tab stop pitch
  localparam int HISTORY_DEPTH = 256;
  localparam int TAB_STOP      = 4;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  // Field widths
  localparam int KIND_W     = 3;
  localparam int CODE_W     = 21;
  localparam int GW_W       = 8;
  localparam int COORD_W    = 10;
  localparam int OP_W       = 2;
  localparam int LH_W       = 8;
  localparam int SW_W       = 8;
  localparam int SL_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  // Wide enough for any intermediate sum or the scroll offset
  localparam int SUM_W      = 14;
  localparam int DIV_CNT_W  = $clog2(COORD_W);
  localparam int POS_W      = $clog2(TAB_STOP + 1);

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  // Register reset values
  localparam logic [COORD_W-1:0] WIDTH_RST  = COORD_W'(320);
  localparam logic [COORD_W-1:0] HEIGHT_RST = COORD_W'(240);
  localparam logic [LH_W-1:0]    LINE_RST   = LH_W'(16);
  localparam logic [SW_W-1:0]    SPACE_RST  = SW_W'(8);
  localparam logic [SL_W-1:0]    SCROLL_RST = SL_W'(8);

  typedef enum logic [KIND_W-1:0] {
    KIND_NEWLINE = 3'd0,
    KIND_CR      = 3'd1,
    KIND_TAB     = 3'd2,
    KIND_BS      = 3'd3,
    KIND_NULL    = 3'd4,
    KIND_PRINT   = 3'd5
  } kind_e;

  typedef enum logic [OP_W-1:0] {
    OP_COPY  = 2'd0,
    OP_FILL  = 2'd1,
    OP_GLYPH = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_WIDTH  = 3'd0,
    CFG_WINDOW_HEIGHT = 3'd1,
    CFG_LINE_HEIGHT   = 3'd2,
    CFG_SPACE_WIDTH   = 3'd3,
    CFG_SCROLL_LINES  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_NEWLINE,
    S_COPY,
    S_SFILL,
    S_DIV,
    S_TAB,
    S_FILL,
    S_GLYPH,
    S_BS
  } state_e;

  // One drawing command
  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] x_left;
    logic [COORD_W-1:0] y_top;
    logic [COORD_W-1:0] x_right;
    logic [COORD_W-1:0] y_bottom;
    logic [COORD_W-1:0] source_y;
    logic [CODE_W-1:0]  glyph_code;
    logic               last;
  } cmd_t;

  // Clamp a non-negative sum to the coordinate range
  function automatic logic [COORD_W-1:0] sat10(input logic [SUM_W-1:0] v);
    logic [COORD_W-1:0] r;
    r = (v > SUM_W'(COORD_MAX)) ? COORD_MAX : v[COORD_W-1:0];
    return r;
  endfunction

endpackage

/* sv/tcce_intf.sv */
// Valid/ready channel interfaces: character input, command output, config writes.
`timescale 1ns / 1ps

interface tcce_item_if;
  import tcce_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] char_code;
  logic [GW_W-1:0]   glyph_width;

  modport source (output valid, kind, char_code, glyph_width, input ready);
  modport sink   (input valid, kind, char_code, glyph_width, output ready);
endinterface

interface tcce_cmd_if;
  import tcce_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [COORD_W-1:0] x_left;
  logic [COORD_W-1:0] y_top;
  logic [COORD_W-1:0] x_right;
  logic [COORD_W-1:0] y_bottom;
  logic [COORD_W-1:0] source_y;
  logic [CODE_W-1:0]  glyph_code;
  logic               last;

  modport source (output valid, op, x_left, y_top, x_right, y_bottom, source_y,
                  glyph_code, last, input ready);
  modport sink   (input valid, op, x_left, y_top, x_right, y_bottom, source_y,
                  glyph_code, last, output ready);
endinterface

interface tcce_cfg_if;
  import tcce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tcce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcce_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/text_console_cursor_engine.sv */
// Text console cursor engine: cursor tracking and drawing command generation.
//
// Usage: item_i takes one decoded character (kind, code point, glyph width).
// cmd_o returns up to four drawing commands per character (scroll copy,
// background fills, glyph draw); the last one of a character has last set.
// cfg_i writes the five window registers and is always ready; the user must
// write them only while idle; the block itself does not enforce it.
// One character at a time: item_i is ready only when the sequencer is idle.
// Each character is accepted and prepared; a newline, or a wrapping tab or
// printable, moves to the next line, adding a scroll copy and fill when the
// window scrolls. A tab runs the bit-serial x / space_width divider, one
// quotient bit per cycle. Each command is built by one sequencer state and
// held in an output register; a stalled cmd_o holds the sequencer in that
// state. The history stack lives in a 256 x 10 RAM with a registered read;
// backspace reads it in the prep state and builds its fill from the data.
// Reset clears cursor, history count and output valid and loads the register
// defaults; the RAM needs no clearing pass, only pushed entries are read.
`timescale 1ns / 1ps

module text_console_cursor_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcce_item_if.sink   item_i,
  tcce_cmd_if.source  cmd_o,
  tcce_cfg_if.sink    cfg_i
);
  import tcce_pkg::*;

  // Configuration registers
  logic [COORD_W-1:0] win_w_q, win_h_q;
  logic [LH_W-1:0]    line_h_q;
  logic [SW_W-1:0]    space_w_q;
  logic [SL_W-1:0]    scroll_l_q;

  // Sequencer and cursor state
  state_e             state_q, state_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Latched character
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [GW_W-1:0]    gw_q, gw_d;

  // Scroll offset and tab divider
  logic [SUM_W-1:0]     ofs_q, ofs_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [SW_W-1:0]      rem_q, rem_d;
  logic [COORD_W-1:0]   quot_q, quot_d;

  // Output register
  logic out_valid_q, out_valid_d;
  cmd_t cmd_q, cmd_d;

  // History RAM
  logic               mem_we, mem_re;
  logic [HIST_AW-1:0] mem_waddr, mem_raddr;
  logic [COORD_W-1:0] mem_rdata;

  // Shared arithmetic
  logic               accept, slot_free, fire;
  logic [SW_W-1:0]    tab_w;
  logic [SUM_W-1:0]   y_line, tab_span, print_right;
  logic               tab_wrap, print_wrap, do_scroll;
  logic [COORD_W-1:0] ofs_clip, y_base, y_bot;
  logic [CNT_W-1:0]   count_dec;
  logic [SW_W:0]      div_trial;
  logic               div_ge;
  logic [SUM_W-1:0]   tab_pos, tab_right;
  state_e             after_nl;

  assign accept    = item_i.valid && item_i.ready;
  assign slot_free = !out_valid_q || cmd_o.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;

  // Geometry helpers
  assign tab_w       = (space_w_q == '0) ? SW_W'(1) : space_w_q;
  assign y_line      = SUM_W'(y_q) + SUM_W'(line_h_q);
  assign y_bot       = sat10(y_line);
  assign tab_span    = SUM_W'(TAB_STOP) * SUM_W'(tab_w);
  assign tab_wrap    = (SUM_W'(x_q) + tab_span) >= SUM_W'(win_w_q);
  assign print_right = SUM_W'(x_q) + SUM_W'(gw_q);
  assign print_wrap  = print_right >= SUM_W'(win_w_q);
  assign do_scroll   = y_line >= SUM_W'(win_h_q);
  assign ofs_clip    = (ofs_q > SUM_W'(win_h_q)) ? win_h_q : ofs_q[COORD_W-1:0];
  assign y_base      = !do_scroll ? y_q :
                       (ofs_q >= SUM_W'(y_q)) ? '0 : (y_q - ofs_q[COORD_W-1:0]);
  assign count_dec   = count_q - CNT_W'(1);

  // Restoring divider step: next quotient bit of x / tab_w
  assign div_trial = {rem_q, x_q[div_cnt_q]};
  assign div_ge    = div_trial >= {1'b0, tab_w};

  // Advance to the next tab stop
  assign tab_pos   = SUM_W'(TAB_STOP) - SUM_W'(quot_q % COORD_W'(TAB_STOP));
  assign tab_right = SUM_W'(x_q) + SUM_W'(tab_pos[POS_W-1:0]) * SUM_W'(tab_w);

  assign after_nl = (kind_q == KIND_TAB)   ? S_DIV :
                    (kind_q == KIND_PRINT) ? S_FILL : S_IDLE;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_PREP;
      end
      S_PREP: begin
        case (kind_q) inside
          KIND_NEWLINE: state_d = S_NEWLINE;
          KIND_TAB:     state_d = tab_wrap ? S_NEWLINE : S_DIV;
          KIND_BS:      state_d = (count_q == '0) ? S_IDLE : S_BS;
          KIND_PRINT:   state_d = print_wrap ? S_NEWLINE : S_FILL;
          KIND_CR, KIND_NULL: state_d = S_IDLE;
          default:      state_d = S_IDLE;
        endcase
      end
      S_NEWLINE: state_d = do_scroll ? S_COPY : after_nl;
      S_COPY:    if (slot_free) state_d = S_SFILL;
      S_SFILL:   if (slot_free) state_d = after_nl;
      S_DIV:     if (div_cnt_q == '0) state_d = S_TAB;
      S_TAB:     if (slot_free) state_d = S_IDLE;
      S_FILL:    if (slot_free) state_d = S_GLYPH;
      S_GLYPH:   if (slot_free) state_d = S_IDLE;
      S_BS:      if (slot_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and command building
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    count_d   = count_q;
    kind_d    = kind_q;
    code_d    = code_q;
    gw_d      = gw_q;
    ofs_d     = ofs_q;
    div_cnt_d = div_cnt_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    cmd_d     = cmd_q;
    fire      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = count_q[HIST_AW-1:0];
    mem_raddr = count_dec[HIST_AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = item_i.kind;
          code_d = item_i.char_code;
          gw_d   = item_i.glyph_width;
          // a full stack restarts at the bottom
          if (count_q == CNT_W'(HISTORY_DEPTH)) count_d = '0;
        end
      end
      S_PREP: begin
        ofs_d     = SUM_W'(scroll_l_q) * SUM_W'(line_h_q);
        div_cnt_d = DIV_CNT_W'(COORD_W - 1);
        rem_d     = '0;
        quot_d    = '0;
        if (kind_q == KIND_CR) begin
          x_d     = '0;
          count_d = '0;
        end
        if (kind_q == KIND_BS && count_q != '0) begin
          count_d = count_dec;
          mem_re  = 1'b1;
        end
      end
      S_NEWLINE: begin
        x_d     = '0;
        count_d = '0;
        y_d     = sat10(SUM_W'(y_base) + SUM_W'(line_h_q));
      end
      S_COPY: begin
        fire             = slot_free;
        cmd_d.op         = OP_COPY;
        cmd_d.x_left     = '0;
        cmd_d.y_top      = '0;
        cmd_d.x_right    = win_w_q;
        cmd_d.y_bottom   = win_h_q - ofs_clip;
        cmd_d.source_y   = ofs_clip;
        cmd_d.glyph_code = '0;
        cmd_d.last       = 1'b0;
      end
      S_SFILL: begin
        fire             = slot_free;
        cmd_d.op         = OP_FILL;
        cmd_d.x_left     = '0;
        cmd_d.y_top      = win_h_q - ofs_clip;
        cmd_d.x_right    = win_w_q;
        cmd_d.y_bottom   = win_h_q;
        cmd_d.source_y   = '0;
        cmd_d.glyph_code = '0;
        cmd_d.last       = (kind_q == KIND_NEWLINE);
      end
      S_DIV: begin
        rem_d     = div_ge ? SW_W'(div_trial - {1'b0, tab_w}) : div_trial[SW_W-1:0];
        quot_d    = {quot_q[COORD_W-2:0], div_ge};
        div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
      end
      S_TAB: begin
        fire             = slot_free;
        cmd_d.op         = OP_FILL;
        cmd_d.x_left     = x_q;
        cmd_d.y_top      = y_q;
        cmd_d.x_right    = sat10(tab_right);
        cmd_d.y_bottom   = y_bot;
        cmd_d.source_y   = '0;
        cmd_d.glyph_code = '0;
        cmd_d.last       = 1'b1;
        if (slot_free) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          x_d     = sat10(tab_right);
        end
      end
      S_FILL: begin
        fire             = slot_free;
        cmd_d.op         = OP_FILL;
        cmd_d.x_left     = x_q;
        cmd_d.y_top      = y_q;
        cmd_d.x_right    = sat10(print_right);
        cmd_d.y_bottom   = y_bot;
        cmd_d.source_y   = '0;
        cmd_d.glyph_code = '0;
        cmd_d.last       = 1'b0;
      end
      S_GLYPH: begin
        fire             = slot_free;
        cmd_d.op         = OP_GLYPH;
        cmd_d.x_left     = x_q;
        cmd_d.y_top      = y_q;
        cmd_d.x_right    = sat10(print_right);
        cmd_d.y_bottom   = y_bot;
        cmd_d.source_y   = '0;
        cmd_d.glyph_code = code_q;
        cmd_d.last       = 1'b1;
        if (slot_free) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          x_d     = sat10(print_right);
        end
      end
      S_BS: begin
        // popped x is in the RAM read register since the prep cycle
        fire             = slot_free;
        cmd_d.op         = OP_FILL;
        cmd_d.x_left     = mem_rdata;
        cmd_d.y_top      = y_q;
        cmd_d.x_right    = x_q;
        cmd_d.y_bottom   = y_bot;
        cmd_d.source_y   = '0;
        cmd_d.glyph_code = '0;
        cmd_d.last       = 1'b1;
        if (slot_free) x_d = mem_rdata;
      end
      default: ;
    endcase
    if (!fire) cmd_d = cmd_q;
  end

  // Output register valid
  always_comb begin
    if (fire)             out_valid_d = 1'b1;
    else if (cmd_o.ready) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    code_q    <= code_d;
    gw_q      <= gw_d;
    ofs_q     <= ofs_d;
    div_cnt_q <= div_cnt_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    cmd_q     <= cmd_d;
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q    <= WIDTH_RST;
      win_h_q    <= HEIGHT_RST;
      line_h_q   <= LINE_RST;
      space_w_q  <= SPACE_RST;
      scroll_l_q <= SCROLL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WINDOW_WIDTH:  win_w_q    <= cfg_i.data;
        CFG_WINDOW_HEIGHT: win_h_q    <= cfg_i.data;
        CFG_LINE_HEIGHT:   line_h_q   <= cfg_i.data[LH_W-1:0];
        CFG_SPACE_WIDTH:   space_w_q  <= cfg_i.data[SW_W-1:0];
        CFG_SCROLL_LINES:  scroll_l_q <= cfg_i.data[SL_W-1:0];
        default: ;
      endcase
    end
  end

  // History stack of earlier x positions
  tcce_ram #(
    .WIDTH (COORD_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (x_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Command output
  assign cmd_o.valid      = out_valid_q;
  assign cmd_o.op         = cmd_q.op;
  assign cmd_o.x_left     = cmd_q.x_left;
  assign cmd_o.y_top      = cmd_q.y_top;
  assign cmd_o.x_right    = cmd_q.x_right;
  assign cmd_o.y_bottom   = cmd_q.y_bottom;
  assign cmd_o.source_y   = cmd_q.source_y;
  assign cmd_o.glyph_code = cmd_q.glyph_code;
  assign cmd_o.last       = cmd_q.last;

endmodule

/* sv/tcce_checker.sv */
// Port-level checks for the cursor engine, bound to the top level.
`timescale 1ns / 1ps

module tcce_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [tcce_pkg::OP_W-1:0] out_op_i,
  input logic                   out_last_i
);
  import tcce_pkg::*;

  // A stalled command stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("command dropped while stalled");

  // One character at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted in back-to-back cycles");

  // A glyph draw always ends its character
  a_glyph_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_op_i == OP_GLYPH) |-> out_last_i)
    else $error("glyph command without last");

  // A scroll copy is never marked last; its fill follows it
  a_copy_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_op_i == OP_COPY) |-> !out_last_i)
    else $error("scroll copy marked last");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (cmd_o.valid),
  .out_ready_i (cmd_o.ready),
  .out_op_i    (cmd_o.op),
  .out_last_i  (cmd_o.last)
);
